// ===== sv/resampling_voice_mixer_macros.svh =====
// assertion macros for the resampling voice mixer
`ifndef RESAMPLING_VOICE_MIXER_MACROS_SVH
`define RESAMPLING_VOICE_MIXER_MACROS_SVH

// same-cycle implication, skipped while reset is high
`define RVM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rvm: assertion failed");

// next-cycle implication, skipped while reset is high
`define RVM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rvm: assertion failed");

`endif

// ===== sv/rvm_pkg.sv =====
// shared types and constants of the resampling voice mixer
`default_nettype none

package rvm_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int MIX_W       = 32;
   localparam int POS_W       = 33;
   localparam int FRAC_W      = 16;
   localparam int FRAME_W     = 17;
   localparam int IDX_W       = POS_W + 1 - FRAC_W;
   localparam int STEP_W      = 24;
   localparam int GAIN_W      = 16;
   localparam int START_W     = 32;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;
   localparam int REQ_DATA_W  = 128;
   localparam int RSP_DATA_W  = 64;
   localparam int ADDR_CALC_W = 21;
   localparam int PROD_W      = 35;
   localparam int INTERP_W    = 34;
   localparam int SCALED_W    = INTERP_W + GAIN_W + 1;
   localparam int ROUND_SHIFT = 28;
   localparam int VOICE_W     = SCALED_W - ROUND_SHIFT;

   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_START = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_COUNT     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SOURCE_CHANNELS = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_OUTPUT_CHANNELS = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_POSITION_STEP   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_GAIN            = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_LOOP_ENABLE     = 3'd5;

   localparam logic [1:0] CHANNELS_STEREO = 2'd2;

   localparam logic [POS_W-1:0]    POS_ROUND_UP = 33'h0_FFFF;
   localparam logic [FRAC_W:0]     FRAC_ONE     = 17'h1_0000;
   localparam logic [SCALED_W-1:0] ROUND_BIAS   = SCALED_W'(1) << (ROUND_SHIFT - 1);

   localparam logic signed [MIX_W-1:0] MIX_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [MIX_W-1:0] MIX_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic [FRAME_W-1:0] frame_count;
      logic [1:0]         source_channels;
      logic [1:0]         output_channels;
      logic [STEP_W-1:0]  position_step;
      logic [GAIN_W-1:0]  gain;
      logic               loop_enable;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      frame_count:     FRAME_W'(1),
      source_channels: 2'd1,
      output_channels: 2'd2,
      position_step:   STEP_W'(65536),
      gain:            GAIN_W'(4096),
      loop_enable:     1'b0
   };

   typedef struct packed {
      logic       latch;
      logic       write;
      logic       start;
      logic       check;
      logic       read;
      logic [1:0] slot;
      logic       mul;
      logic       sum;
      logic       scale;
      logic       finish;
   } cmd_type;

   typedef struct packed {
      logic will_play;
   } status_type;

endpackage

`default_nettype wire

// ===== sv/rvm_regs.sv =====
// configuration register file of the resampling voice mixer
`default_nettype none

module rvm_regs
   import rvm_pkg::*;
(
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    csr_valid,
   output logic                   csr_ready,
   input  wire [CSR_INDEX_W-1:0]  csr_index,
   input  wire [CSR_DATA_W-1:0]   csr_data,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_FRAME_COUNT:     cfg_in.frame_count     = csr_data[FRAME_W-1:0];
            REG_SOURCE_CHANNELS: cfg_in.source_channels = csr_data[1:0];
            REG_OUTPUT_CHANNELS: cfg_in.output_channels = csr_data[1:0];
            REG_POSITION_STEP:   cfg_in.position_step   = csr_data[STEP_W-1:0];
            REG_GAIN:            cfg_in.gain            = csr_data[GAIN_W-1:0];
            REG_LOOP_ENABLE:     cfg_in.loop_enable     = csr_data[0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

endmodule

`default_nettype wire

// ===== sv/rvm_ctrl.sv =====
// controller state machine of the resampling voice mixer
`default_nettype none

module rvm_ctrl
   import rvm_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire [1:0]   req_op,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   input  wire status_type status,
   output cmd_type     cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WRITE,
      ST_START,
      ST_CHECK,
      ST_READ,
      ST_LAST,
      ST_MUL,
      ST_SUM,
      ST_SCALE,
      ST_FIN
   } state_type;

   localparam logic [1:0] SLOT_LAST = 2'd3;

   state_type  state_ff, state_in;
   logic [1:0] slot_ff, slot_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      slot_in  = slot_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.latch = 1'b1;
               unique case (req_op)
                  OP_LOAD:  state_in = ST_WRITE;
                  OP_START: state_in = ST_START;
                  OP_TICK:  state_in = ST_CHECK;
                  default:  state_in = ST_IDLE;
               endcase
            end
         end
         ST_WRITE: begin
            cmd.write = 1'b1;
            state_in  = ST_IDLE;
         end
         ST_START: begin
            cmd.start = 1'b1;
            state_in  = ST_IDLE;
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            slot_in   = '0;
            state_in  = status.will_play ? ST_READ : ST_FIN;
         end
         ST_READ: begin
            // lo left, lo right, hi left, hi right on the single read port (a mono source reads lo, lo, hi, hi)
            cmd.read = 1'b1;
            cmd.slot = slot_ff;
            slot_in  = slot_ff + 2'd1;
            if (slot_ff == SLOT_LAST) begin
               state_in = ST_LAST;
            end
         end
         ST_LAST: begin
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum  = 1'b1;
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_FIN;
         end
         ST_FIN: begin
            // hold here while the previous result is still untaken
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         slot_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== sv/rvm_dp.sv =====
// datapath of the resampling voice mixer: sample store, position, interpolation, gain and mix
`default_nettype none

module rvm_dp
   import rvm_pkg::*;
#(
   parameter int STORE_WORDS = 65536
)
(
   input  wire                   clock,
   input  wire                   reset,
   input  wire cfg_type          cfg,
   input  wire cmd_type          cmd,
   output status_type            status,
   input  wire [REQ_DATA_W-1:0]  req_tdata,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [0:0]            rsp_tuser
);

   localparam int AW = $clog2(STORE_WORDS);

   function automatic logic signed [MIX_W-1:0] sat_add(
      input logic signed [MIX_W-1:0]   mix,
      input logic signed [VOICE_W-1:0] v
   );
      logic signed [MIX_W:0] s;
      s = {mix[MIX_W-1], mix} + {{(MIX_W + 1 - VOICE_W){v[VOICE_W-1]}}, v};
      if (s[MIX_W] != s[MIX_W-1]) begin
         sat_add = s[MIX_W] ? MIX_MIN : MIX_MAX;
      end else begin
         sat_add = s[MIX_W-1:0];
      end
   endfunction

   // latched request
   logic [SAMPLE_W-1:0]        addr_ff;
   logic signed [SAMPLE_W-1:0] value_ff;
   logic [START_W-1:0]         start_ff;
   logic signed [MIX_W-1:0]    mix_l_ff, mix_r_ff;

   // play state
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             playing_ff, playing_in;

   // store and read pipeline
   logic signed [SAMPLE_W-1:0] store_mem [STORE_WORDS];
   logic signed [SAMPLE_W-1:0] mem_q_ff;
   logic                       rd_pend_ff, rd_zero_ff;
   logic [1:0]                 rd_slot_ff;
   logic signed [SAMPLE_W-1:0] words_ff [4];

   // arithmetic
   logic signed [PROD_W-1:0]   p_lo_ff [2], p_hi_ff [2];
   logic signed [PROD_W-1:0]   p_lo_in [2], p_hi_in [2];
   logic signed [INTERP_W-1:0] interp_ff [2];
   logic signed [SCALED_W-1:0] scaled_ff [2];
   logic signed [SCALED_W-1:0] biased [2];
   logic signed [VOICE_W-1:0]  voice [2];
   logic signed [MIX_W-1:0]    out_l_ff, out_r_ff;
   logic                       active_ff;

   logic                       src_st, out_st, sum_pair;
   logic [IDX_W-1:0]           lo_idx, hi_idx, frame;
   logic [POS_W:0]             pos_up;
   logic                       end_hit;
   logic [ADDR_CALC_W-1:0]     rd_addr, wr_addr;
   logic                       rd_zero, wr_ok;
   logic [FRAC_W-1:0]          frac;
   logic [FRAC_W:0]            w_lo;
   logic signed [FRAC_W+1:0]   wl_s, wh_s;
   logic signed [SAMPLE_W:0]   f_lo [2], f_hi [2];
   logic signed [GAIN_W:0]     gain_s;

   assign src_st   = (cfg.source_channels == CHANNELS_STEREO);
   assign out_st   = (cfg.output_channels == CHANNELS_STEREO);
   assign sum_pair = src_st && !out_st;

   assign lo_idx  = {1'b0, pos_ff[POS_W-1:FRAC_W]};
   assign pos_up  = {1'b0, pos_ff} + {1'b0, POS_ROUND_UP};
   assign hi_idx  = pos_up[POS_W:FRAC_W];
   assign end_hit = hi_idx > {1'b0, cfg.frame_count};

   assign status.will_play = playing_ff && !(end_hit && !cfg.loop_enable);

   always_comb begin
      pos_in     = pos_ff;
      playing_in = playing_ff;
      priority if (cmd.start) begin
         pos_in     = POS_W'(start_ff);
         playing_in = 1'b1;
      end else if (cmd.check) begin
         // end of data: rewind, and stop unless looping
         if (playing_ff && end_hit) begin
            pos_in     = '0;
            playing_in = cfg.loop_enable;
         end
      end else if (cmd.finish && playing_ff) begin
         pos_in = pos_ff + POS_W'(cfg.position_step);
      end else begin
         pos_in     = pos_ff;
         playing_in = playing_ff;
      end
   end

   // read address of slot: frame from slot bit 1, channel from slot bit 0 for a stereo source
   assign frame   = cmd.slot[1] ? hi_idx : lo_idx;
   assign rd_addr = src_st ? ADDR_CALC_W'({frame, cmd.slot[0]}) : ADDR_CALC_W'(frame);
   assign rd_zero = (frame >= {1'b0, cfg.frame_count})
                 || (rd_addr >= ADDR_CALC_W'(STORE_WORDS));
   assign wr_addr = ADDR_CALC_W'(addr_ff);
   assign wr_ok   = wr_addr < ADDR_CALC_W'(STORE_WORDS);

   always_ff @(posedge clock) begin
      if (cmd.write && wr_ok) begin
         store_mem[wr_addr[AW-1:0]] <= value_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         mem_q_ff <= store_mem[rd_addr[AW-1:0]];
      end
   end

   assign frac   = pos_ff[FRAC_W-1:0];
   assign w_lo   = FRAC_ONE - {1'b0, frac};
   assign wl_s   = $signed({1'b0, w_lo});
   assign wh_s   = $signed({2'b00, frac});
   assign gain_s = $signed({1'b0, cfg.gain});

   always_comb begin
      // channel 0: left, or left plus right for a stereo source on a mono mix
      f_lo[0] = sum_pair ? ({words_ff[0][SAMPLE_W-1], words_ff[0]}
                           + {words_ff[1][SAMPLE_W-1], words_ff[1]})
                         : {words_ff[0][SAMPLE_W-1], words_ff[0]};
      f_hi[0] = sum_pair ? ({words_ff[2][SAMPLE_W-1], words_ff[2]}
                           + {words_ff[3][SAMPLE_W-1], words_ff[3]})
                         : {words_ff[2][SAMPLE_W-1], words_ff[2]};
      // channel 1: right of a stereo source, else the mono source again
      f_lo[1] = src_st ? {words_ff[1][SAMPLE_W-1], words_ff[1]}
                       : {words_ff[0][SAMPLE_W-1], words_ff[0]};
      f_hi[1] = src_st ? {words_ff[3][SAMPLE_W-1], words_ff[3]}
                       : {words_ff[2][SAMPLE_W-1], words_ff[2]};
      for (int c = 0; c < 2; c++) begin
         p_lo_in[c] = f_lo[c] * wl_s;
         p_hi_in[c] = f_hi[c] * wh_s;
         biased[c]  = scaled_ff[c] + $signed(ROUND_BIAS);
         voice[c]   = $signed(biased[c][SCALED_W-1:ROUND_SHIFT]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         playing_ff <= 1'b0;
         rd_pend_ff <= 1'b0;
      end else begin
         pos_ff     <= pos_in;
         playing_ff <= playing_in;
         rd_pend_ff <= cmd.read;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         addr_ff  <= req_tdata[15:0];
         value_ff <= req_tdata[31:16];
         start_ff <= req_tdata[63:32];
         mix_l_ff <= req_tdata[95:64];
         mix_r_ff <= req_tdata[127:96];
      end
      if (cmd.read) begin
         rd_zero_ff <= rd_zero;
         rd_slot_ff <= cmd.slot;
      end
      if (rd_pend_ff) begin
         words_ff[rd_slot_ff] <= rd_zero_ff ? '0 : mem_q_ff;
      end
      for (int c = 0; c < 2; c++) begin
         if (cmd.mul) begin
            p_lo_ff[c] <= p_lo_in[c];
            p_hi_ff[c] <= p_hi_in[c];
         end
         if (cmd.sum) begin
            interp_ff[c] <= INTERP_W'(p_lo_ff[c] + p_hi_ff[c]);
         end
         if (cmd.scale) begin
            scaled_ff[c] <= interp_ff[c] * gain_s;
         end
      end
      if (cmd.finish) begin
         out_l_ff  <= playing_ff ? sat_add(mix_l_ff, voice[0]) : mix_l_ff;
         out_r_ff  <= (playing_ff && out_st) ? sat_add(mix_r_ff, voice[1]) : mix_r_ff;
         active_ff <= playing_ff;
      end
   end

   assign rsp_tdata = {out_r_ff, out_l_ff};
   assign rsp_tuser = active_ff;

endmodule

`default_nettype wire

// ===== sv/resampling_voice_mixer.sv =====
// top level of the resampling voice mixer: one linear-interpolation playback voice
//
//   channel  ports    direction  payload
//   request  req_*    in         tuser: operation; tdata: address, value, start, mix l, mix r
//   result   rsp_*    out        tuser: voice_active; tdata: mix out l, mix out r
//   config   csr_*    in         csr_index: register, csr_data: value
//
// a tick on a playing voice makes four sample store reads through the one read port,
// then passes through multiply, sum, gain and mix stages before the next request is taken
// a tick that passes the mix through skips the reads; an unknown operation is taken and dropped
// a result waits in the output register; the next tick holds in its last step until it is taken
// synchronous reset clears control and play state and resets the config; the store is not cleared
`default_nettype none
`include "resampling_voice_mixer_macros.svh"

module resampling_voice_mixer
   import rvm_pkg::*;
#(
   parameter int STORE_WORDS = 65536
)
(
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_tvalid,
   output logic                   req_tready,
   // [15:0] sample_address, [31:16] sample_value, [63:32] start_position,
   // [95:64] mix_in_left, [127:96] mix_in_right
   input  wire [REQ_DATA_W-1:0]   req_tdata,
   // [1:0] operation
   input  wire [1:0]              req_tuser,
   output logic                   rsp_tvalid,
   input  wire                    rsp_tready,
   // [31:0] mix_out_left, [63:32] mix_out_right
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   // [0] voice_active
   output logic [0:0]             rsp_tuser,
   input  wire                    csr_valid,
   output logic                   csr_ready,
   input  wire [CSR_INDEX_W-1:0]  csr_index,
   input  wire [CSR_DATA_W-1:0]   csr_data
);

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   rvm_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   rvm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   rvm_dp #(
      .STORE_WORDS (STORE_WORDS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd       (cmd),
      .status    (status),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   // a known operation always leaves the block busy in the cycle after it is accepted
   `RVM_ASSERT_NEXT(a_busy_after_request, clock, reset, req_tvalid && req_tready && (req_tuser == OP_LOAD || req_tuser == OP_START || req_tuser == OP_TICK), !req_tready)
   `RVM_ASSERT_NEXT(a_finish_shows_result, clock, reset, cmd.finish, rsp_tvalid)
   `RVM_ASSERT_IMP(a_one_command, clock, reset, 1'b1, $onehot0({cmd.latch, cmd.write, cmd.start, cmd.check, cmd.read, cmd.mul, cmd.sum, cmd.scale, cmd.finish}))

endmodule

`default_nettype wire
